FILE: rtl/stu_pkg.sv
`timescale 1ns / 1ps
package stu_pkg;

  localparam int LINE_BITS   = 16;
  localparam int COLUMN_BITS = 16;
  localparam int NKEYS       = 13;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    M_TOP, M_WORD, M_NUM, M_CH_OPEN, M_CH_ESC, M_CH_CLOSE, M_STR, M_STR_ESC, M_ERR
  } mode_t;

  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_TOKEN = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [4:0] TK_NONE   = 5'd0;
  localparam logic [4:0] TK_CHAR   = 5'd12;
  localparam logic [4:0] TK_STRING = 5'd13;
  localparam logic [4:0] TK_NUMBER = 5'd14;
  localparam logic [4:0] TK_IDENT  = 5'd15;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_CH_ESC    = 3'd0;
  localparam logic [2:0] ERR_CH_CLOSE  = 3'd1;
  localparam logic [2:0] ERR_STR_ESC   = 3'd2;
  localparam logic [2:0] ERR_STR_NL    = 3'd3;
  localparam logic [2:0] ERR_BAD_BYTE  = 3'd4;
  localparam logic [2:0] ERR_END_LIT   = 3'd5;

  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
  localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;

  // keyword text, left-justified, NUL padded
  localparam logic [63:0] KEY_TEXT [NKEYS] = '{
    {"void", 32'h0}, {"int8", 32'h0}, {"int16", 24'h0}, {"int32", 24'h0},
    {"int64", 24'h0}, {"uint8", 24'h0}, {"uint16", 16'h0}, {"uint32", 16'h0},
    {"uint64", 16'h0}, {"float32", 8'h0}, {"float64", 8'h0},
    {"string", 16'h0}, {"char", 32'h0}
  };
  localparam logic [3:0] KEY_LEN [NKEYS] = '{
    4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5, 4'd6, 4'd6, 4'd6, 4'd7, 4'd7, 4'd6, 4'd4
  };
  localparam logic [4:0] KEY_KIND [NKEYS] = '{
    5'd16, 5'd17, 5'd17, 5'd17, 5'd17, 5'd18, 5'd18, 5'd18, 5'd18,
    5'd19, 5'd19, 5'd20, 5'd21
  };

  typedef struct packed {
    logic [1:0]             kind;
    logic [7:0]             ch;
    logic [4:0]             tk;
    logic [2:0]             ek;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] scol;
    logic [COLUMN_BITS-1:0] ecol;
    logic                   last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } bundle_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_wordch(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_" || c == "-";
  endfunction

  // {found, index}
  function automatic logic [4:0] op_index(logic [7:0] c);
    logic [4:0] r;
    case (c)
      ";": r = {1'b1, 4'd0};
      "=": r = {1'b1, 4'd1};
      "+": r = {1'b1, 4'd2};
      "-": r = {1'b1, 4'd3};
      "*": r = {1'b1, 4'd4};
      "/": r = {1'b1, 4'd5};
      "%": r = {1'b1, 4'd6};
      "(": r = {1'b1, 4'd7};
      ")": r = {1'b1, 4'd8};
      ",": r = {1'b1, 4'd9};
      "{": r = {1'b1, 4'd10};
      "}": r = {1'b1, 4'd11};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // returns {new length, new alive mask}
  function automatic logic [NKEYS+3:0] word_add(logic [3:0] len, logic [NKEYS-1:0] alive,
                                                logic [7:0] c);
    logic [NKEYS-1:0] a;
    a = alive;
    if (len >= 4'd8) return {len, {NKEYS{1'b0}}};
    for (int k = 0; k < NKEYS; k++) begin
      if (KEY_LEN[k] <= len || KEY_TEXT[k][63 - 8*len[2:0] -: 8] != c) a[k] = 1'b0;
    end
    return {len + 4'd1, a};
  endfunction

  function automatic logic [4:0] word_kind(logic [NKEYS-1:0] alive, logic [3:0] len);
    logic [4:0] r;
    r = TK_IDENT;
    for (int k = NKEYS - 1; k >= 0; k--) begin
      if (alive[k] && KEY_LEN[k] == len) r = KEY_KIND[k];
    end
    return r;
  endfunction

  function automatic logic [COLUMN_BITS-1:0] col_inc(logic [COLUMN_BITS-1:0] c);
    return (c == COL_MAX) ? c : c + 1'b1;
  endfunction

  function automatic result_t mk(logic [1:0] kind, logic [7:0] ch, logic [4:0] tk,
                                 logic [2:0] ek, logic [LINE_BITS-1:0] line,
                                 logic [COLUMN_BITS-1:0] s, logic [COLUMN_BITS-1:0] e);
    result_t r;
    r.kind = kind; r.ch = ch; r.tk = tk; r.ek = ek;
    r.line = line; r.scol = s; r.ecol = e; r.last = 1'b0;
    return r;
  endfunction

  // appends a result, dropping anything past two
  function automatic bundle_t push(bundle_t b, result_t r);
    bundle_t o;
    o = b;
    if (b.n == 2'd0) begin
      o.r0 = r; o.n = 2'd1;
    end else if (b.n == 2'd1) begin
      o.r1 = r; o.n = 2'd2;
    end
    return o;
  endfunction

endpackage

FILE: rtl/stu_in_if.sv
`timescale 1ns / 1ps
interface stu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       final_byte;
  modport source (output valid, char_in, final_byte, input ready);
  modport sink (input valid, char_in, final_byte, output ready);
endinterface

FILE: rtl/stu_out_if.sv
`timescale 1ns / 1ps
interface stu_out_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      item_kind;
  logic [7:0]                      char_out;
  logic [4:0]                      token_kind;
  logic [2:0]                      error_kind;
  logic [stu_pkg::LINE_BITS-1:0]   line_number;
  logic [stu_pkg::COLUMN_BITS-1:0] start_column;
  logic [stu_pkg::COLUMN_BITS-1:0] end_column;
  logic                            run_last;
  modport source (output valid, item_kind, char_out, token_kind, error_kind, line_number,
                  start_column, end_column, run_last, input ready);
  modport sink (input valid, item_kind, char_out, token_kind, error_kind, line_number,
                start_column, end_column, run_last, output ready);
endinterface

FILE: rtl/stu_front.sv
`timescale 1ns / 1ps
module stu_front (
  input  logic             clk,
  input  logic             rst,
  stu_in_if.sink           src,
  input  logic             q_full,
  output logic             q_push,
  output stu_pkg::bundle_t q_data
);

  stu_pkg::mode_t                    mode, mode_next;
  logic [stu_pkg::LINE_BITS-1:0]     line, line_next;
  logic [stu_pkg::COLUMN_BITS-1:0]   col, col_next;
  logic [stu_pkg::COLUMN_BITS-1:0]   tstart, tstart_next;
  logic [3:0]                        wlen, wlen_next;
  logic [stu_pkg::NKEYS-1:0]         alive, alive_next;
  logic [7:0]                        lit, lit_next;
  stu_pkg::bundle_t                  b;
  logic                              do_top, nl, take;
  logic [7:0]                        c;
  logic [4:0]                        op;

  assign src.ready = !q_full;
  assign take      = src.valid && src.ready;
  assign c         = src.char_in;
  assign op        = stu_pkg::op_index(c);

  always_comb begin
    mode_next = mode; line_next = line; col_next = col; tstart_next = tstart;
    wlen_next = wlen; alive_next = alive; lit_next = lit;
    b = '0; do_top = 1'b0; nl = 1'b0;

    case (mode)
      stu_pkg::M_WORD: begin
        if (stu_pkg::is_wordch(c)) begin
          {wlen_next, alive_next} = stu_pkg::word_add(wlen, alive, c);
          b = stu_pkg::push(b, stu_pkg::mk(stu_pkg::KIND_CHAR, c, stu_pkg::TK_IDENT,
                stu_pkg::ERR_NONE, line, tstart, col));
        end else begin
          b = stu_pkg::push(b, stu_pkg::mk(stu_pkg::KIND_TOKEN, 8'd0,
                stu_pkg::word_kind(alive, wlen), stu_pkg::ERR_NONE, line, tstart, col));
          mode_next = stu_pkg::M_TOP;
          do_top = 1'b1;
        end
      end
      stu_pkg::M_NUM: begin
        if (stu_pkg::is_digit(c)) begin
          b = stu_pkg::push(b, stu_pkg::mk(stu_pkg::KIND_CHAR, c, stu_pkg::TK_NUMBER,
                stu_pkg::ERR_NONE, line, tstart, col));
        end else begin
          b = stu_pkg::push(b, stu_pkg::mk(stu_pkg::KIND_TOKEN, 8'd0, stu_pkg::TK_NUMBER,
                stu_pkg::ERR_NONE, line, tstart, col));
          mode_next = stu_pkg::M_TOP;
          do_top = 1'b1;
        end
      end
      stu_pkg::M_CH_OPEN: begin
        if (c == "\\") begin
          mode_next = stu_pkg::M_CH_ESC;
        end else begin
          lit_next = c;
          mode_next = stu_pkg::M_CH_CLOSE;
        end
      end
      stu_pkg::M_CH_ESC: begin
        mode_next = stu_pkg::M_CH_CLOSE;
        if (c == "n") lit_next = 8'h0a;
        else if (c == "t") lit_next = 8'h09;
        else if (c == "'" || c == "\\") lit_next = c;
        else begin
          b = stu_pkg::push(b, stu_pkg::mk(stu_pkg::KIND_ERROR, 8'd0, stu_pkg::TK_NONE,
                stu_pkg::ERR_CH_ESC, line, col, col));
          mode_next = stu_pkg::M_ERR;
        end
      end
      stu_pkg::M_CH_CLOSE: begin
        if (c == "'") begin
          b = stu_pkg::push(b, stu_pkg::mk(stu_pkg::KIND_TOKEN, lit, stu_pkg::TK_CHAR,
                stu_pkg::ERR_NONE, line, tstart, col));
          mode_next = stu_pkg::M_TOP;
        end else begin
          b = stu_pkg::push(b, stu_pkg::mk(stu_pkg::KIND_ERROR, 8'd0, stu_pkg::TK_NONE,
                stu_pkg::ERR_CH_CLOSE, line, col, col));
          mode_next = stu_pkg::M_ERR;
        end
      end
      stu_pkg::M_STR: begin
        if (c == "\"") begin
          b = stu_pkg::push(b, stu_pkg::mk(stu_pkg::KIND_TOKEN, 8'd0, stu_pkg::TK_STRING,
                stu_pkg::ERR_NONE, line, tstart, col));
          mode_next = stu_pkg::M_TOP;
        end else if (c == "\\") begin
          mode_next = stu_pkg::M_STR_ESC;
        end else if (c == 8'h0a) begin
          b = stu_pkg::push(b, stu_pkg::mk(stu_pkg::KIND_ERROR, 8'd0, stu_pkg::TK_NONE,
                stu_pkg::ERR_STR_NL, line, col, col));
          mode_next = stu_pkg::M_ERR;
        end else begin
          b = stu_pkg::push(b, stu_pkg::mk(stu_pkg::KIND_CHAR, c, stu_pkg::TK_STRING,
                stu_pkg::ERR_NONE, line, tstart, col));
        end
      end
      stu_pkg::M_STR_ESC: begin
        mode_next = stu_pkg::M_STR;
        if (c == "n" || c == "t" || c == "\\" || c == "\"") begin
          b = stu_pkg::push(b, stu_pkg::mk(stu_pkg::KIND_CHAR,
                (c == "n") ? 8'h0a : ((c == "t") ? 8'h09 : c),
                stu_pkg::TK_STRING, stu_pkg::ERR_NONE, line, tstart, col));
        end else begin
          b = stu_pkg::push(b, stu_pkg::mk(stu_pkg::KIND_ERROR, 8'd0, stu_pkg::TK_NONE,
                stu_pkg::ERR_STR_ESC, line, col, col));
          mode_next = stu_pkg::M_ERR;
        end
      end
      stu_pkg::M_TOP: do_top = 1'b1;
      default: mode_next = stu_pkg::M_ERR;
    endcase

    // top-level handling, also for the byte that closed a word or number
    if (do_top) begin
      if (c == " ") begin
        // skipped
      end else if (c == 8'h0a) begin
        nl = 1'b1;
        if (line != stu_pkg::LINE_MAX) line_next = line + 1'b1;
      end else if (op[4]) begin
        b = stu_pkg::push(b, stu_pkg::mk(stu_pkg::KIND_TOKEN, 8'd0, {1'b0, op[3:0]},
              stu_pkg::ERR_NONE, line, col, col));
      end else begin
        tstart_next = col;
        if (c == "'") begin
          mode_next = stu_pkg::M_CH_OPEN;
        end else if (c == "\"") begin
          mode_next = stu_pkg::M_STR;
        end else if (stu_pkg::is_alpha(c) || c == "_") begin
          {wlen_next, alive_next} = stu_pkg::word_add(4'd0, '1, c);
          b = stu_pkg::push(b, stu_pkg::mk(stu_pkg::KIND_CHAR, c, stu_pkg::TK_IDENT,
                stu_pkg::ERR_NONE, line, col, col));
          mode_next = stu_pkg::M_WORD;
        end else if (stu_pkg::is_digit(c)) begin
          b = stu_pkg::push(b, stu_pkg::mk(stu_pkg::KIND_CHAR, c, stu_pkg::TK_NUMBER,
                stu_pkg::ERR_NONE, line, col, col));
          mode_next = stu_pkg::M_NUM;
        end else begin
          b = stu_pkg::push(b, stu_pkg::mk(stu_pkg::KIND_ERROR, 8'd0, stu_pkg::TK_NONE,
                stu_pkg::ERR_BAD_BYTE, line, col, col));
          mode_next = stu_pkg::M_ERR;
        end
      end
    end

    if (src.final_byte) begin
      if (mode_next == stu_pkg::M_WORD) begin
        b = stu_pkg::push(b, stu_pkg::mk(stu_pkg::KIND_TOKEN, 8'd0,
              stu_pkg::word_kind(alive_next, wlen_next), stu_pkg::ERR_NONE, line,
              tstart_next, stu_pkg::col_inc(col)));
      end else if (mode_next == stu_pkg::M_NUM) begin
        b = stu_pkg::push(b, stu_pkg::mk(stu_pkg::KIND_TOKEN, 8'd0, stu_pkg::TK_NUMBER,
              stu_pkg::ERR_NONE, line, tstart_next, stu_pkg::col_inc(col)));
      end else if (mode_next != stu_pkg::M_TOP && mode_next != stu_pkg::M_ERR) begin
        b = stu_pkg::push(b, stu_pkg::mk(stu_pkg::KIND_ERROR, 8'd0, stu_pkg::TK_NONE,
              stu_pkg::ERR_END_LIT, line, col, col));
      end
      mode_next = stu_pkg::M_TOP; line_next = stu_pkg::LINE_BITS'(1); col_next = '0;
      tstart_next = '0; wlen_next = '0; alive_next = '1; lit_next = '0;
    end else begin
      col_next = nl ? stu_pkg::COLUMN_BITS'(1) : stu_pkg::col_inc(col);
    end

    if (b.n == 2'd1) b.r0.last = 1'b1;
    else if (b.n == 2'd2) b.r1.last = 1'b1;
  end

  assign q_push = take && (b.n != 2'd0);
  assign q_data = b;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= stu_pkg::M_TOP; line <= stu_pkg::LINE_BITS'(1); col <= '0; tstart <= '0;
      wlen <= '0; alive <= '1; lit <= '0;
    end else if (take) begin
      mode <= mode_next; line <= line_next; col <= col_next; tstart <= tstart_next;
      wlen <= wlen_next; alive <= alive_next; lit <= lit_next;
    end
  end

endmodule

FILE: rtl/stu_queue.sv
`timescale 1ns / 1ps
module stu_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  stu_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output stu_pkg::bundle_t head
);

  stu_pkg::bundle_t             mem [stu_pkg::QUEUE_DEPTH];
  logic [stu_pkg::QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [stu_pkg::QUEUE_AW:0]   count;

  assign full  = count == (stu_pkg::QUEUE_AW+1)'(stu_pkg::QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0; rd_ptr <= '0; count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

FILE: rtl/stu_back.sv
`timescale 1ns / 1ps
module stu_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  stu_pkg::bundle_t q_head,
  output logic             q_pop,
  stu_out_if.source        tok
);

  logic             sel;
  logic             load;
  stu_pkg::result_t cur, outr;
  logic             out_valid;

  assign load  = !q_empty && (!out_valid || tok.ready);
  assign cur   = sel ? q_head.r1 : q_head.r0;
  assign q_pop = load && (sel || q_head.n == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0; sel <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sel <= !q_pop;
      end else if (tok.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) outr <= cur;
  end

  assign tok.valid        = out_valid;
  assign tok.item_kind    = outr.kind;
  assign tok.char_out     = outr.ch;
  assign tok.token_kind   = outr.tk;
  assign tok.error_kind   = outr.ek;
  assign tok.line_number  = outr.line;
  assign tok.start_column = outr.scol;
  assign tok.end_column   = outr.ecol;
  assign tok.run_last     = outr.last;

endmodule

FILE: rtl/source_tokenizer_unit.sv
`timescale 1ns / 1ps
// Source tokenizer: byte-serial lexer for a small C-like language.
// src channel: one source byte per transfer (char_in, final_byte marks the
// last byte of the text). tok channel: result items, payload characters,
// token-complete items and errors, each with line and column positions;
// run_last flags the final result caused by a byte.
// The front end classifies a byte combinationally and takes one byte every
// cycle while the four-entry result queue has room. Each byte yields zero,
// one or two results; the back end sends one result per cycle while the
// receiver is ready, through a registered output, so the two results of a
// byte leave one after the other. The first result of a byte is written to
// the queue at the byte's transfer edge, then to the output register for tok.
// Reset (synchronous, rst high) returns the lexer to top level, line 1,
// column 0, and empties the queue and output register; the final byte does
// the same to the lexer state. When the receiver stalls, the output holds,
// the queue fills, and then src.ready drops until room frees up.
module source_tokenizer_unit (
  input  logic       clk,
  input  logic       rst,
  stu_in_if.sink     src,
  stu_out_if.source  tok
);

  logic             q_full, q_push, q_pop, q_empty;
  stu_pkg::bundle_t q_data, q_head;

  // classifier and lexer state
  stu_front u_front (
    .clk(clk), .rst(rst), .src(src),
    .q_full(q_full), .q_push(q_push), .q_data(q_data)
  );

  // result bundles between the two halves
  stu_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_data(q_data), .full(q_full),
    .pop(q_pop), .empty(q_empty), .head(q_head)
  );

  // splits bundles into single result transfers
  stu_back u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop), .tok(tok)
  );

endmodule
